// ----- hdl/pdd_pkg.sv -----
`timescale 1ns / 1ps

package pdd_pkg;

   // window geometry
   localparam int LONG_FRAME_LEN  = 18;
   localparam int MID_FRAME_LEN   = 7;
   localparam int SHORT_FRAME_LEN = 4;

   localparam int CNT_W = $clog2(LONG_FRAME_LEN + 1);
   localparam int IDX_W = $clog2(LONG_FRAME_LEN);

   localparam logic [CNT_W-1:0] LONG_CNT  = CNT_W'(LONG_FRAME_LEN);
   localparam logic [CNT_W-1:0] MID_CNT   = CNT_W'(MID_FRAME_LEN);
   localparam logic [CNT_W-1:0] SHORT_CNT = CNT_W'(SHORT_FRAME_LEN);

   // checksum sweep runs over entries 1 .. LONG_FRAME_LEN-2
   localparam logic [IDX_W-1:0] SUM_IDX_FIRST = IDX_W'(1);
   localparam logic [IDX_W-1:0] SUM_IDX_SHORT = IDX_W'(SHORT_FRAME_LEN - 2);
   localparam logic [IDX_W-1:0] SUM_IDX_MID   = IDX_W'(MID_FRAME_LEN - 2);
   localparam logic [IDX_W-1:0] SUM_IDX_LAST  = IDX_W'(LONG_FRAME_LEN - 2);

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] OP_ZERO   = 8'h00;

   // opcodes accepted in byte 2 of a seven-byte command, listed from entry 7 down to entry 0
   localparam int NUM_MID_OPCODES = 8;
   localparam logic [NUM_MID_OPCODES-1:0][7:0] MID_OPCODES =
      {8'hF1, 8'hF0, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01, 8'h00};

   // frame kinds
   localparam logic [1:0] KIND_SHORT = 2'd0;
   localparam logic [1:0] KIND_MID   = 2'd1;
   localparam logic [1:0] KIND_LONG  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic load;        // append the accepted byte
      logic drop;        // discard the head byte
      logic sum_start;   // clear checksum sweep
      logic sum_step;    // add one entry to the sweep
      logic emit_load;   // latch the matching frame
      logic emit_shift;  // one frame byte taken
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic head_sync;
      logic full;
      logic sum_done;
      logic any_match;
      logic emit_last;
   } sts_type;

   function automatic logic opcode_allowed(input logic [7:0] op);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NUM_MID_OPCODES; i++) begin
         hit = hit | (op == MID_OPCODES[i]);
      end
      return hit;
   endfunction

endpackage

// ----- hdl/pdd_ctrl.sv -----
`timescale 1ns / 1ps

module pdd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_stream_end,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  pdd_pkg::sts_type  sts,
   output pdd_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SUM,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      end_ff, end_in;

   always_comb begin
      state_in  = state_ff;
      end_in    = end_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               end_in   = req_stream_end;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.empty) begin
               state_in = ST_IDLE;
            end else if (!sts.head_sync) begin
               cmd.drop = 1'b1;
            end else if (!sts.full && !end_ff) begin
               state_in = ST_IDLE;
            end else begin
               cmd.sum_start = 1'b1;
               state_in      = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (sts.sum_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.any_match) begin
               cmd.emit_load = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               cmd.drop = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               cmd.emit_shift = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
      end
   end

endmodule

// ----- hdl/pdd_datapath.sv -----
`timescale 1ns / 1ps

module pdd_datapath (
   input  logic              clock,
   input  logic              reset,
   input  pdd_pkg::cmd_type  cmd,
   output pdd_pkg::sts_type  sts,
   input  logic [7:0]        req_in_byte,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_frame_first,
   output logic              rsp_frame_last,
   output logic [1:0]        rsp_frame_kind
);

   logic [7:0] win_ff [pdd_pkg::LONG_FRAME_LEN];

   logic [pdd_pkg::CNT_W-1:0] count_ff, count_in;
   logic [pdd_pkg::IDX_W-1:0] idx_ff;
   logic [7:0]                acc_ff, acc_in;
   logic [7:0]                sum_short_ff, sum_mid_ff, sum_long_ff;
   logic [pdd_pkg::CNT_W-1:0] emit_len_ff, emit_rem_ff;
   logic [1:0]                kind_ff;
   logic                      match_long, match_mid, match_short;
   logic                      shift;

   assign acc_in = acc_ff + win_ff[idx_ff];
   assign shift  = cmd.drop || cmd.emit_shift;

   assign match_long  = (count_ff >= pdd_pkg::LONG_CNT) &&
                        (sum_long_ff == win_ff[pdd_pkg::LONG_FRAME_LEN-1]);
   assign match_mid   = (count_ff >= pdd_pkg::MID_CNT) &&
                        pdd_pkg::opcode_allowed(win_ff[2]) &&
                        (sum_mid_ff == win_ff[pdd_pkg::MID_FRAME_LEN-1]);
   assign match_short = (count_ff >= pdd_pkg::SHORT_CNT) &&
                        (win_ff[2] == pdd_pkg::OP_ZERO) &&
                        (sum_short_ff == win_ff[pdd_pkg::SHORT_FRAME_LEN-1]);

   always_comb begin
      sts.empty     = (count_ff == '0);
      sts.head_sync = (win_ff[0] == pdd_pkg::SYNC_BYTE);
      sts.full      = (count_ff >= pdd_pkg::LONG_CNT);
      sts.sum_done  = (idx_ff == pdd_pkg::SUM_IDX_LAST);
      sts.any_match = match_long || match_mid || match_short;
      sts.emit_last = (emit_rem_ff == pdd_pkg::CNT_W'(1));
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.load) begin
         count_in = count_ff + pdd_pkg::CNT_W'(1);
      end else if (shift) begin
         count_in = count_ff - pdd_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // window store, head at entry 0
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         win_ff[count_ff[pdd_pkg::IDX_W-1:0]] <= req_in_byte;
      end else if (shift) begin
         for (int k = 0; k < pdd_pkg::LONG_FRAME_LEN - 1; k++) begin
            win_ff[k] <= win_ff[k+1];
         end
      end
   end

   // checksum sweep, one entry per cycle
   always_ff @(posedge clock) begin
      if (cmd.sum_start) begin
         idx_ff <= pdd_pkg::SUM_IDX_FIRST;
         acc_ff <= '0;
      end else if (cmd.sum_step) begin
         idx_ff <= idx_ff + pdd_pkg::IDX_W'(1);
         acc_ff <= acc_in;
         if (idx_ff == pdd_pkg::SUM_IDX_SHORT) begin
            sum_short_ff <= acc_in;
         end
         if (idx_ff == pdd_pkg::SUM_IDX_MID) begin
            sum_mid_ff <= acc_in;
         end
         if (idx_ff == pdd_pkg::SUM_IDX_LAST) begin
            sum_long_ff <= acc_in;
         end
      end
   end

   // frame emission tracking
   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         if (match_long) begin
            emit_len_ff <= pdd_pkg::LONG_CNT;
            emit_rem_ff <= pdd_pkg::LONG_CNT;
            kind_ff     <= pdd_pkg::KIND_LONG;
         end else if (match_mid) begin
            emit_len_ff <= pdd_pkg::MID_CNT;
            emit_rem_ff <= pdd_pkg::MID_CNT;
            kind_ff     <= pdd_pkg::KIND_MID;
         end else begin
            emit_len_ff <= pdd_pkg::SHORT_CNT;
            emit_rem_ff <= pdd_pkg::SHORT_CNT;
            kind_ff     <= pdd_pkg::KIND_SHORT;
         end
      end else if (cmd.emit_shift) begin
         emit_rem_ff <= emit_rem_ff - pdd_pkg::CNT_W'(1);
      end
   end

   assign rsp_out_byte    = win_ff[0];
   assign rsp_frame_first = (emit_rem_ff == emit_len_ff);
   assign rsp_frame_last  = (emit_rem_ff == pdd_pkg::CNT_W'(1));
   assign rsp_frame_kind  = kind_ff;

endmodule

// ----- hdl/pelco_d_stream_deframer.sv -----
`timescale 1ns / 1ps
// sequencing: after the accept the head is scanned, and scanned again after every dropped byte
//   and after every frame; each frame check sweeps entries 1 .. LONG_FRAME_LEN-2, then decides
// response: one frame byte per cycle while rsp_stall is low, then scanning resumes
// flow: request stalled from accept until the window settles, so no new byte is taken meanwhile;
//   when the head only waits for more bytes, the scan goes straight back to idle
// reset: synchronous active high, window emptied, controller back to idle
module pelco_d_stream_deframer (
   input  logic       clock,
   input  logic       reset,
   // request channel: one stream byte per transaction
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_stream_end,
   // response channel: one frame byte per transaction
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_first,
   output logic       rsp_frame_last,
   output logic [1:0] rsp_frame_kind
);

   // command and status between sequencer and window datapath
   pdd_pkg::cmd_type cmd;
   pdd_pkg::sts_type sts;

   // sequencer: idle, scan head, checksum sweep, decide, emit
   pdd_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_stream_end (req_stream_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .sts            (sts),
      .cmd            (cmd)
   );

   // window shift register, checksum accumulator and frame counters
   pdd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_in_byte     (req_in_byte),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_frame_first (rsp_frame_first),
      .rsp_frame_last  (rsp_frame_last),
      .rsp_frame_kind  (rsp_frame_kind)
   );

endmodule

// ----- tb/sv/pelco_d_stream_deframer_tb.sv -----
`timescale 1ns / 1ps

module pelco_d_stream_deframer_tb;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 3;
   localparam int RANDOM_ITEMS = 215;
   // worst case per byte: full window of failing syncs, each costing a checksum sweep
   localparam int TAIL_CYCLES  = 500;
   localparam int CYCLE_LIMIT  = 600000;

   // one frame byte as it should leave the response channel
   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
      logic [1:0] kind;
   } frame_byte_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte    = 8'h00;
   logic       req_stream_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_frame_first;
   logic       rsp_frame_last;
   logic [1:0] rsp_frame_kind;

   // predictor copy of the byte window, head at index 0
   logic [7:0]     window_q [$];
   // frame bytes predicted but not yet seen on the response side
   frame_byte_type pending_frame_bytes [$];

   bit failed       = 1'b0;
   int cycle_count  = 0;
   int bytes_sent   = 0;
   int burst_left   = 0;

   // receiver stall pattern state
   int stall_mode = 0;
   int mode_left  = 0;

   pelco_d_stream_deframer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_stream_end  (req_stream_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_frame_first (rsp_frame_first),
      .rsp_frame_last  (rsp_frame_last),
      .rsp_frame_kind  (rsp_frame_kind)
   );

   always #HALF_PERIOD clock = ~clock;

   // watchdog: a hung handshake or a lost frame byte ends here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // window predictor
   // ---------------------------------------------------------------------

   // 8-bit sum of entries between sync and checksum against the last entry
   function automatic bit checksum_holds(input int len);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 1; i < len - 1; i++) acc += window_q[i];
      return acc == window_q[len - 1];
   endfunction

   // move the head frame of the window into the expected stream
   task automatic take_frame(input int len, input logic [1:0] kind);
      for (int i = 0; i < len; i++) begin
         pending_frame_bytes.push_back(frame_byte_type'{
            data:  window_q[i],
            first: (i == 0),
            last:  (i == len - 1),
            kind:  kind});
      end
      repeat (len) void'(window_q.pop_front());
   endtask

   // append one stream byte and resolve the window as far as it goes
   task automatic scan_window(input logic [7:0] rx_byte, input logic rx_end);
      bit op_ok;
      window_q.push_back(rx_byte);
      while (window_q.size() > 0) begin
         // junk ahead of a sync byte never survives
         if (window_q[0] != pdd_pkg::SYNC_BYTE) begin
            void'(window_q.pop_front());
            continue;
         end
         // sync at the head but not enough bytes yet and no end mark: wait
         if (window_q.size() < pdd_pkg::LONG_FRAME_LEN && !rx_end) break;
         op_ok = 1'b0;
         if (window_q.size() > 2) begin
            for (int i = 0; i < pdd_pkg::NUM_MID_OPCODES; i++)
               if (window_q[2] == pdd_pkg::MID_OPCODES[i]) op_ok = 1'b1;
         end
         // longest candidate first, then command, then short response
         if (window_q.size() >= pdd_pkg::LONG_FRAME_LEN &&
             checksum_holds(pdd_pkg::LONG_FRAME_LEN)) begin
            take_frame(pdd_pkg::LONG_FRAME_LEN, pdd_pkg::KIND_LONG);
         end else if (window_q.size() >= pdd_pkg::MID_FRAME_LEN && op_ok &&
                      checksum_holds(pdd_pkg::MID_FRAME_LEN)) begin
            take_frame(pdd_pkg::MID_FRAME_LEN, pdd_pkg::KIND_MID);
         end else if (window_q.size() >= pdd_pkg::SHORT_FRAME_LEN &&
                      window_q[2] == pdd_pkg::OP_ZERO &&
                      checksum_holds(pdd_pkg::SHORT_FRAME_LEN)) begin
            take_frame(pdd_pkg::SHORT_FRAME_LEN, pdd_pkg::KIND_SHORT);
         end else begin
            // no candidate fits: lose the sync byte and rescan
            void'(window_q.pop_front());
         end
      end
      // end of stream leaves nothing behind
      if (rx_end) window_q.delete();
   endtask

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // one stream byte per transaction, sent in bursts with random gaps
   task automatic send_byte(input logic [7:0] rx_byte, input logic rx_end);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         case ($urandom_range(0, 7))
            0, 1, 2: gap = 0;
            7:       gap = $urandom_range(20, 60);
            default: gap = $urandom_range(1, 6);
         endcase
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_in_byte    <= rx_byte;
      req_stream_end <= rx_end;
      // each byte is taken in order, so its frames can be predicted now
      scan_window(rx_byte, rx_end);
      bytes_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // send a byte sequence, optionally marking the last byte as stream end
   task automatic send_seq(input logic [7:0] seq_bytes [$], input bit end_last);
      foreach (seq_bytes[i]) send_byte(seq_bytes[i], end_last && (i == seq_bytes.size() - 1));
   endtask

   // checksum over everything after the sync byte
   function automatic logic [7:0] body_sum(input logic [7:0] seq_bytes [$]);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 1; i < seq_bytes.size(); i++) acc += seq_bytes[i];
      return acc;
   endfunction

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------

   // stall pattern switches between free running, sparse, periodic and heavy
   always @(negedge clock) begin
      if (mode_left == 0) begin
         mode_left  = $urandom_range(16, 160);
         stall_mode = $urandom_range(0, 3);
      end
      mode_left--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ((cycle_count % 8) < 5);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // compare every accepted frame byte with the oldest prediction
   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frame_bytes.size() == 0) begin
            failed = 1'b1;
            $error("unexpected frame byte %02h first %0b last %0b kind %0d",
                   rsp_out_byte, rsp_frame_first, rsp_frame_last, rsp_frame_kind);
         end else begin
            want = pending_frame_bytes.pop_front();
            if (rsp_out_byte !== want.data) begin
               failed = 1'b1;
               $error("out_byte: expected %02h, got %02h", want.data, rsp_out_byte);
            end
            if (rsp_frame_first !== want.first) begin
               failed = 1'b1;
               $error("frame_first: expected %0b, got %0b", want.first, rsp_frame_first);
            end
            if (rsp_frame_last !== want.last) begin
               failed = 1'b1;
               $error("frame_last: expected %0b, got %0b", want.last, rsp_frame_last);
            end
            if (rsp_frame_kind !== want.kind) begin
               failed = 1'b1;
               $error("frame_kind: expected %0d, got %0d", want.kind, rsp_frame_kind);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // junk byte, a sync that fits no frame, then a short response closed by end mark
   task automatic test_short_frame();
      logic [7:0] seq_bytes [$];
      seq_bytes = {8'h00, pdd_pkg::SYNC_BYTE, pdd_pkg::SYNC_BYTE, 8'h80, pdd_pkg::OP_ZERO};
      seq_bytes.push_back(8'h80);
      send_seq(seq_bytes, 1'b1);
   endtask

   // seven-byte command with the top opcode, resolved by end mark
   task automatic test_mid_frame();
      logic [7:0] seq_bytes [$];
      seq_bytes = {pdd_pkg::SYNC_BYTE, 8'h01,
                   pdd_pkg::MID_OPCODES[pdd_pkg::NUM_MID_OPCODES - 1],
                   8'h55, 8'hAA, 8'hFF};
      seq_bytes.push_back(body_sum(seq_bytes));
      send_seq(seq_bytes, 1'b1);
   endtask

   // long query response with extreme bytes, resolved by a full window alone
   task automatic test_long_frame();
      logic [7:0] seq_bytes [$];
      seq_bytes = {pdd_pkg::SYNC_BYTE, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55,
                   8'hAA, 8'h0F, 8'hF0, 8'h33, 8'hCC, 8'hFF, 8'h00, 8'h12, 8'hED};
      seq_bytes.push_back(body_sum(seq_bytes));
      send_seq(seq_bytes, 1'b0);
   endtask

   // mostly well-formed frames with random content, plus noise and broken frames
   task automatic test_random_stream();
      logic [7:0] seq_bytes [$];
      int start_count;
      int pick;
      int n;
      start_count = bytes_sent;
      while (bytes_sent - start_count < RANDOM_ITEMS) begin
         seq_bytes.delete();
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // seven-byte command
            seq_bytes = {pdd_pkg::SYNC_BYTE, 8'($urandom),
                         pdd_pkg::MID_OPCODES[$urandom_range(0, pdd_pkg::NUM_MID_OPCODES - 1)],
                         8'($urandom), 8'($urandom), 8'($urandom)};
            seq_bytes.push_back(body_sum(seq_bytes));
         end else if (pick < 60) begin
            // four-byte response
            seq_bytes = {pdd_pkg::SYNC_BYTE, 8'($urandom), pdd_pkg::OP_ZERO};
            seq_bytes.push_back(body_sum(seq_bytes));
         end else if (pick < 70) begin
            // long query response
            seq_bytes.push_back(pdd_pkg::SYNC_BYTE);
            repeat (pdd_pkg::LONG_FRAME_LEN - 2) seq_bytes.push_back(8'($urandom));
            seq_bytes.push_back(body_sum(seq_bytes));
         end else if (pick < 85) begin
            // line noise, sync bytes included
            n = $urandom_range(1, 4);
            repeat (n) seq_bytes.push_back(($urandom_range(0, 2) == 0) ? pdd_pkg::SYNC_BYTE
                                                                       : 8'($urandom));
         end else begin
            // truncated command
            seq_bytes = {pdd_pkg::SYNC_BYTE, 8'($urandom),
                         pdd_pkg::MID_OPCODES[$urandom_range(0, pdd_pkg::NUM_MID_OPCODES - 1)],
                         8'($urandom), 8'($urandom)};
            seq_bytes = seq_bytes[0:$urandom_range(1, 4)];
         end
         // some frames carry a corrupted checksum
         if (pick < 70 && $urandom_range(0, 9) == 0)
            seq_bytes[seq_bytes.size() - 1] ^= 8'($urandom_range(1, 255));
         send_seq(seq_bytes, $urandom_range(0, 9) == 0);
      end
      // close the stream so the window drains
      send_byte(8'($urandom), 1'b1);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_short_frame();
      test_mid_frame();
      test_long_frame();
      test_random_stream();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frame_bytes.size() != 0) @(posedge clock);
      // let any stray scan finish so late extra bytes are caught
      repeat (TAIL_CYCLES) @(posedge clock);

      if (!failed && pending_frame_bytes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
